// File: hw/rtl/sdp_pkg.sv
// Shared types and codes for the deck permuter.
// No dependencies.
package sdp_pkg;
    typedef enum logic [2:0] {
        REQ_WRITE = 3'd0,
        REQ_MOVE1 = 3'd1,
        REQ_MOVE2 = 3'd2,
        REQ_TCUT  = 3'd3,
        REQ_CCUT  = 3'd4,
        REQ_READ  = 3'd5
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_SCAN,
        ST_MOVE_RD,
        ST_MOVE_WR,
        ST_WRAP,
        ST_COPY,
        ST_BACK,
        ST_RDWAIT,
        ST_OUT
    } state_t;
endpackage

// File: hw/rtl/sdp_ram.sv
// Single-port-write, single-read synchronous memory with registered read data.
// Depends on nothing.
module sdp_ram #(
    parameter int DEPTH = 54,
    parameter int AW = 6
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [5:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [5:0]    rdata
);
    logic [5:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: hw/rtl/solitaire_deck_permuter_unit.sv
// Solitaire deck permuter top level: sequencer and two deck memories.
// Depends on sdp_pkg and sdp_ram.
//
// One request is handled at a time. After reset a clearing pass loads the
// ordered deck; no request is taken during it. A write goes straight to the
// result state, and a read waits in ST_RDWAIT for the registered memory data.
// A move scans the deck memory one entry per cycle then swaps, or for a bottom
// card shifts the deck one entry per cycle; a two-place move runs this twice.
// A triple cut scans once and then copies through the scratch memory and
// back; a count cut copies and copies back. Each memory has a single read
// port, so every pass reads one entry at a time.
module solitaire_deck_permuter_unit
    import sdp_pkg::*;
#(
    parameter int DECK_SIZE = 54
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_req_type,
    input  logic [5:0] s_pos,
    input  logic [5:0] s_card,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [5:0] m_read_value
);
    localparam int AW = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] N = CW'(DECK_SIZE);
    localparam logic [5:0] JOKER = 6'((DECK_SIZE - 1) % 64);

    state_t state_reg, state_next;
    logic [2:0] typ_reg, typ_next;
    logic [5:0] pos_reg, pos_next, card_reg, card_next;
    logic [5:0] out_reg, out_next;
    logic       pass_reg, pass_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] first_reg, first_next, last_reg, last_next;
    logic       ffound_reg, ffound_next, lfound_reg, lfound_next;
    logic [CW-1:0] phase_reg, phase_next;

    logic          dwe, twe;
    logic [AW-1:0] dwa, dra, twa, tra;
    logic [5:0]    dwd, drd, twd, trd;

    sdp_ram #(.DEPTH(DECK_SIZE), .AW(AW)) u_deck (
        .aclk(aclk), .we(dwe), .waddr(dwa), .wdata(dwd), .raddr(dra), .rdata(drd)
    );
    sdp_ram #(.DEPTH(DECK_SIZE), .AW(AW)) u_tmp (
        .aclk(aclk), .we(twe), .waddr(twa), .wdata(twd), .raddr(tra), .rdata(trd)
    );

    assign s_ready = (state_reg == ST_IDLE);
    // Hide the pass between the two halves of a two-place move
    assign m_valid = (state_reg == ST_OUT) && !(typ_reg == REQ_MOVE2 && !pass_reg);
    assign m_read_value = out_reg;

    // Hold control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
        typ_reg <= typ_next;     pos_reg <= pos_next;
        card_reg <= card_next;   out_reg <= out_next;
        pass_reg <= pass_next;   first_reg <= first_next;
        last_reg <= last_next;   ffound_reg <= ffound_next;
        lfound_reg <= lfound_next;
        phase_reg <= phase_next;
    end

    // Source index for the copy phase; phase 0 copy out, read of idx from deck
    function automatic logic [CW-1:0] cut_src(input logic [2:0] t, input logic [CW-1:0] k,
                                              input logic [CW-1:0] f, input logic [CW-1:0] l,
                                              input logic [5:0] c);
        logic [CW-1:0] nlow, nmid, ccnt, top;
        nlow = N - l - CW'(1);
        nmid = l - f + CW'(1);
        ccnt = CW'(c);
        top  = N - CW'(1) - ccnt;
        if (t == REQ_TCUT) begin
            if (k < nlow) return l + CW'(1) + k;
            else if (k < nlow + nmid) return f + (k - nlow);
            else return k - nlow - nmid;
        end else begin
            if (k == N - CW'(1)) return k;
            else if (k < top) return ccnt + k;
            else return k - top;
        end
    endfunction

    // Sequence the request
    always_comb begin
        state_next = state_reg; idx_next = idx_reg;
        typ_next = typ_reg; pos_next = pos_reg; card_next = card_reg;
        out_next = out_reg; pass_next = pass_reg; first_next = first_reg;
        last_next = last_reg; ffound_next = ffound_reg; lfound_next = lfound_reg;
        phase_next = phase_reg;
        dwe = 1'b0; dwa = idx_reg[AW-1:0]; dwd = card_reg;
        dra = idx_reg[AW-1:0];
        twe = 1'b0; twa = phase_reg[AW-1:0]; twd = drd;
        tra = idx_reg[AW-1:0];
        unique case (state_reg)
            ST_INIT: begin
                dwe = 1'b1;
                dwd = 6'(idx_reg + CW'(1));
                idx_next = idx_reg + CW'(1);
                if (idx_reg == N - CW'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    typ_next = s_req_type; pos_next = s_pos; card_next = s_card;
                    out_next = '0; pass_next = 1'b0; idx_next = '0;
                    ffound_next = 1'b0; lfound_next = 1'b0;
                    case (s_req_type) inside
                        REQ_WRITE: begin
                            if ({1'b0, s_pos} < 7'(DECK_SIZE)) begin
                                dwe = 1'b1; dwa = s_pos[AW-1:0]; dwd = s_card;
                            end
                            state_next = ST_OUT;
                        end
                        REQ_READ: begin
                            dra = s_pos[AW-1:0];
                            state_next = ST_RDWAIT;
                        end
                        REQ_MOVE1, REQ_MOVE2, REQ_TCUT: begin
                            dra = '0;
                            idx_next = CW'(1);
                            phase_next = '0;
                            state_next = ST_SCAN;
                        end
                        REQ_CCUT: begin
                            if ({1'b0, s_pos} < 7'(DECK_SIZE - 1)) begin
                                phase_next = '0;
                                dra = AW'(cut_src(REQ_CCUT, '0, '0, '0, s_pos));
                                state_next = ST_COPY;
                            end else begin
                                state_next = ST_OUT;
                            end
                        end
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_RDWAIT: begin
                if ({1'b0, pos_reg} < 7'(DECK_SIZE)) out_next = drd;
                state_next = ST_OUT;
            end
            // idx_reg is address issued this cycle; drd holds entry phase_reg
            ST_SCAN: begin
                dra = idx_reg[AW-1:0];
                idx_next = idx_reg + CW'(1);
                phase_next = phase_reg + CW'(1);
                if (typ_reg == REQ_TCUT) begin
                    if (drd >= JOKER) begin
                        if (!ffound_next && !ffound_reg) begin
                            first_next = phase_reg; ffound_next = 1'b1;
                        end else begin
                            last_next = phase_reg; lfound_next = 1'b1;
                        end
                    end
                    if (phase_reg == N - CW'(1)) begin
                        if (ffound_next && lfound_next) begin
                            phase_next = '0;
                            dra = AW'(cut_src(REQ_TCUT, '0, first_next, last_next, '0));
                            state_next = ST_COPY;
                        end else begin
                            state_next = ST_OUT;
                        end
                    end
                end else begin
                    if (drd == card_reg) begin
                        first_next = phase_reg;
                        if (phase_reg == N - CW'(1)) begin
                            // bottom card wraps: shift entries 1..N-2 down one
                            idx_next = N - CW'(2);
                            dra = AW'(N - CW'(2));
                            state_next = ST_WRAP;
                        end else begin
                            dra = AW'(phase_reg + CW'(1));
                            state_next = ST_MOVE_RD;
                        end
                    end else if (phase_reg == N - CW'(1)) begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_MOVE_RD: begin
                // drd = entry below; swap
                dwe = 1'b1; dwa = first_reg[AW-1:0]; dwd = drd;
                state_next = ST_MOVE_WR;
            end
            ST_MOVE_WR: begin
                dwe = 1'b1; dwa = AW'(first_reg + CW'(1)); dwd = card_reg;
                state_next = ST_OUT;
            end
            ST_WRAP: begin
                // drd = entry idx_reg; write it one lower, walk upward
                dwe = 1'b1; dwa = AW'(idx_reg + CW'(1)); dwd = drd;
                if (idx_reg == CW'(1)) begin
                    state_next = ST_MOVE_WR;
                    first_next = '0;
                end else begin
                    idx_next = idx_reg - CW'(1);
                    dra = AW'(idx_reg - CW'(1));
                end
                if (idx_reg == CW'(1)) state_next = ST_MOVE_WR;
            end
            ST_COPY: begin
                // drd = deck[src(phase)]; store into scratch at phase
                twe = 1'b1; twa = phase_reg[AW-1:0]; twd = drd;
                dra = AW'(cut_src(typ_reg, phase_reg + CW'(1), first_reg, last_reg,
                                  pos_reg));
                phase_next = phase_reg + CW'(1);
                if (phase_reg == N - CW'(1)) begin
                    phase_next = '0;
                    tra = '0;
                    state_next = ST_BACK;
                end
            end
            ST_BACK: begin
                dwe = 1'b1; dwa = phase_reg[AW-1:0]; dwd = trd;
                tra = AW'(phase_reg + CW'(1));
                phase_next = phase_reg + CW'(1);
                if (phase_reg == N - CW'(1)) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (typ_reg == REQ_MOVE2 && !pass_reg) begin
                    // second one-place move, searching anew
                    pass_next = 1'b1;
                    dra = '0; idx_next = CW'(1); phase_next = '0;
                    state_next = ST_SCAN;
                end else if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// File: hw/rtl/sdp_checker.sv
// Port checker for the deck permuter, bound to the top level.
// Depends on solitaire_deck_permuter_unit ports only.
module sdp_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [5:0] m_read_value
);
    // One request in flight: never ready while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid)) else $error("ready while result pending");
    // A result holds until taken
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_read_value))
        else $error("result dropped or changed");
    // After acceptance no ready on the next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready) else $error("second request taken");
    // After a result is taken, no result next cycle
    a_once: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid) else $error("result repeated");
endmodule

bind solitaire_deck_permuter_unit sdp_checker u_sdp_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_read_value(m_read_value)
);

// File: sim/tb_solitaire_deck_permuter_unit.sv
// Testbench for the solitaire deck permuter: random and directed deck requests
// checked against an in-bench deck model. Depends on sdp_pkg and the RTL.
module tb_solitaire_deck_permuter_unit
    import sdp_pkg::*;
();

    localparam int NCARDS = 54;
    localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [2:0] s_req_type;
    logic [5:0] s_pos;
    logic [5:0] s_card;
    logic       m_valid;
    logic       m_ready;
    logic [5:0] m_read_value;

    logic [5:0] model_deck [NCARDS];
    logic [5:0] read_expect_q [$];
    int         err_count;
    bit         idle_enable;
    int         hold_cycles;

    solitaire_deck_permuter_unit #(.DECK_SIZE(NCARDS)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_req_type(s_req_type),
        .s_pos(s_pos), .s_card(s_card),
        .m_valid(m_valid), .m_ready(m_ready), .m_read_value(m_read_value)
    );

    // Generate the clock
    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        err_count++;
    endtask

    // Move the first copy of a card down one place, wrapping below the top
    function automatic void deck_step_down(input logic [5:0] c);
        for (int i = 0; i < NCARDS; i++) begin
            if (model_deck[i] == c) begin
                if (i < NCARDS - 1) begin
                    model_deck[i] = model_deck[i + 1];
                    model_deck[i + 1] = c;
                end else begin
                    for (int j = NCARDS - 1; j >= 2; j--) model_deck[j] = model_deck[j - 1];
                    model_deck[1] = c;
                end
                return;
            end
        end
    endfunction

    // Apply one request to the deck copy and return the read result
    function automatic logic [5:0] deck_apply(input logic [2:0] rt, input logic [5:0] p,
                                              input logic [5:0] c);
        logic [5:0] tmp [NCARDS];
        int first;
        int last;
        int n;
        first = -1;
        last = -1;
        n = 0;
        case (rt)
            REQ_WRITE: if (p < NCARDS) model_deck[p] = c;
            REQ_MOVE1: deck_step_down(c);
            REQ_MOVE2: begin
                deck_step_down(c);
                deck_step_down(c);
            end
            REQ_TCUT: begin
                for (int i = 0; i < NCARDS; i++)
                    if (model_deck[i] >= NCARDS - 1) begin
                        if (first < 0) first = i;
                        else last = i;
                    end
                if (first >= 0 && last >= 0) begin
                    for (int i = last + 1; i < NCARDS; i++) tmp[n++] = model_deck[i];
                    for (int i = first; i <= last; i++) tmp[n++] = model_deck[i];
                    for (int i = 0; i < first; i++) tmp[n++] = model_deck[i];
                    model_deck = tmp;
                end
            end
            REQ_CCUT: begin
                if (p < NCARDS - 1) begin
                    for (int i = p; i < NCARDS - 1; i++) tmp[n++] = model_deck[i];
                    for (int i = 0; i < p; i++) tmp[n++] = model_deck[i];
                    tmp[NCARDS - 1] = model_deck[NCARDS - 1];
                    model_deck = tmp;
                end
            end
            REQ_READ: if (p < NCARDS) return model_deck[p];
            default: ;
        endcase
        return 6'd0;
    endfunction

    // Send one transaction, with optional random gaps before it
    task automatic send_req(input logic [2:0] rt, input logic [5:0] p, input logic [5:0] c);
        while (idle_enable && $urandom_range(99) < 38) @(posedge aclk);
        s_valid <= 1'b1;
        s_req_type <= rt;
        s_pos <= p;
        s_card <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        read_expect_q = {read_expect_q, deck_apply(rt, p, c)};
        s_valid <= 1'b0;
        // Let the drop settle before the next transaction
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        while (read_expect_q.size() != 0) @(posedge aclk);
    endtask

    // Drive the result-side ready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            m_ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end else begin
            m_ready <= !(idle_enable && $urandom_range(99) < 38);
        end
    end

    // Check each result transaction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (read_expect_q.size() == 0) begin
                report_mismatch("result with nothing expected");
            end else begin
                if (m_read_value !== read_expect_q[0])
                    report_mismatch($sformatf("read_value %0d, expected %0d",
                                              m_read_value, read_expect_q[0]));
                void'(read_expect_q.pop_front());
            end
        end
    end

    task automatic test_directed();
        send_req(REQ_READ, 6'd0, 6'd1);
        send_req(REQ_READ, 6'd53, 6'd1);
        send_req(REQ_READ, 6'd63, 6'd63);
        send_req(REQ_MOVE1, 6'd0, 6'd54);
        send_req(REQ_MOVE2, 6'd0, 6'd53);
        send_req(REQ_MOVE1, 6'd0, 6'd60);
        send_req(REQ_TCUT, 6'd0, 6'd0);
        send_req(REQ_CCUT, 6'd0, 6'd0);
        send_req(REQ_CCUT, 6'd52, 6'd0);
        send_req(REQ_CCUT, 6'd53, 6'd0);
        send_req(REQ_CCUT, 6'd63, 6'd0);
        send_req(REQ_WRITE, 6'd63, 6'd63);
        send_req(REQ_WRITE, 6'd0, 6'd0);
        send_req(REQ_WRITE, 6'd5, 6'd54);
        send_req(REQ_TCUT, 6'd0, 6'd0);
        send_req(REQ_UNUSED_LO, 6'd10, 6'd10);
        send_req(REQ_UNUSED_HI, 6'd63, 6'd63);
        send_req(REQ_WRITE, 6'd53, 6'd7);
        send_req(REQ_MOVE1, 6'd0, 6'd7);
        send_req(REQ_READ, 6'd1, 6'd0);
        send_req(REQ_READ, 6'd5, 6'd0);
    endtask

    // Fill, hold off the receiver, then pause until drained
    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 2000;
        for (int i = 0; i < 6; i++) send_req(REQ_READ, 6'($urandom_range(53)), 6'd0);
        wait_drained();
    endtask

    task automatic test_random(input int count, input bit legal);
        logic [2:0] rt;
        for (int i = 0; i < count; i++) begin
            rt = legal ? 3'($urandom_range(5)) : 3'($urandom);
            send_req(rt, legal ? 6'($urandom_range(53)) : 6'($urandom),
                     ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(54, 1)));
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_req_type = '0;
        s_pos = '0;
        s_card = '0;
        err_count = 0;
        idle_enable = 1'b1;
        hold_cycles = 0;
        for (int i = 0; i < NCARDS; i++) model_deck[i] = 6'(i + 1);
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_backpressure();
        test_random(900, 1'b1);
        idle_enable = 1'b0;
        test_random(200, 1'b1);
        idle_enable = 1'b1;
        test_random(250, 1'b0);
        wait_drained();
        repeat (400) @(posedge aclk);
        if (err_count == 0 && read_expect_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

// File: files.f
hw/rtl/sdp_pkg.sv
hw/rtl/sdp_ram.sv
hw/rtl/solitaire_deck_permuter_unit.sv
hw/rtl/sdp_checker.sv
sim/tb_solitaire_deck_permuter_unit.sv
